// File: hw/rtl/r2mb_pkg.sv
// shared constants and item types for the mono bitmap writer
package r2mb_pkg;

  localparam int MAX_WIDTH  = 512;
  localparam int MAX_HEIGHT = 256;

  localparam int unsigned STORE_BYTES = ((MAX_WIDTH + 7) / 8) * MAX_HEIGHT;
  localparam int SA_W  = $clog2(STORE_BYTES);
  localparam int CNT_W = $clog2(STORE_BYTES + 1);

  // field widths
  localparam int MODE_W = 2;
  localparam int POS_W  = 12;
  localparam int COL_W  = 8;
  localparam int RI_W   = 14;
  localparam int TW_W   = 10;
  localparam int TH_W   = 9;
  localparam int STR_W  = TW_W - 2;
  localparam int BC_W   = TW_W - 3;
  localparam int RB_W   = TH_W + STR_W;
  localparam int PROD_W = TW_W + POS_W;
  localparam int LUMA_W = 15;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  localparam logic [TW_W-1:0] TW_RESET = TW_W'(400);
  localparam logic [TH_W-1:0] TH_RESET = TH_W'(160);

  // luma weights, threshold scaled by the divisor
  localparam int LUMA_R     = 30;
  localparam int LUMA_G     = 59;
  localparam int LUMA_B     = 11;
  localparam int LUMA_LIMIT = 128 * 100;

  localparam logic [MODE_W-1:0] MODE_INIT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DRAW = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ = 2'd2;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;
    logic [POS_W-1:0]  width;
    logic [POS_W-1:0]  height;
    logic [COL_W-1:0]  red;
    logic [COL_W-1:0]  green;
    logic [COL_W-1:0]  blue;
    logic [COL_W-1:0]  alpha;
    logic [RI_W-1:0]   read_index;
  } in_item_t;

  typedef struct packed {
    logic             status_ok;
    logic [COL_W-1:0] read_byte;
  } out_item_t;

endpackage

// File: hw/rtl/r2mb_if.sv
// valid/ready channel interfaces for command items and result items
interface r2mb_in_if;
  import r2mb_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface r2mb_out_if;
  import r2mb_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: hw/rtl/r2mb_ram.sv
// generic single write port, single read port ram with registered read
module r2mb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/rgba_to_mono_bitmap_writer.sv
// top level: packed 1bpp bitmap writer with init, draw and read-back
//
// in_ch carries one command item per handshake (valid/ready): mode 0 checks an
// image size against the target registers and clears the bitmap, mode 1 paints
// a clipped rectangle in one rgba colour, mode 2 reads one bitmap byte back.
// out_ch returns one item per command: status_ok and read_byte.
// target_width and target_height sit on the apb port at 0x0 and 0x4; write
// them only while no command is in flight.
// Items are handled one at a time, the bitmap lives in a 16384 x 8 ram.
//   unused mode, failed init or refused draw: the response step only
//   read: ram read, then response; a draw that misses the target area: clip, then response
//   init: size count, then a clear sweep of one cleared byte per cycle, then response
//   draw: clip, base, then one bitmap byte per cycle (rows x byte columns),
//         read-modify-written through the single ram port pair, then response
// Results go to an output register, so a new item is taken while the last
// result still waits; a stalled receiver only holds the next item at its end.
// Reset (rst_n low, synchronous) clears status to ok, marks no image loaded
// and restores the targets to 400 x 160; bitmap contents stay undefined.
module rgba_to_mono_bitmap_writer (
  input  logic                         clk,
  input  logic                         rst_n,
  r2mb_in_if.sink                      in_ch,
  r2mb_out_if.source                   out_ch,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [r2mb_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [r2mb_pkg::CFG_DW-1:0]  cfg_pwdata,
  output logic [r2mb_pkg::CFG_DW-1:0]  cfg_prdata,
  output logic                         cfg_pready
);
  import r2mb_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ICNT  = 3'd1;
  localparam logic [2:0] ST_CLEAR = 3'd2;
  localparam logic [2:0] ST_DCLIP = 3'd3;
  localparam logic [2:0] ST_DBASE = 3'd4;
  localparam logic [2:0] ST_DRAW  = 3'd5;
  localparam logic [2:0] ST_READ  = 3'd6;
  localparam logic [2:0] ST_RESP  = 3'd7;

  localparam logic REG_TW = 1'b0;
  localparam logic REG_TH = 1'b1;

  logic [2:0]        state_r, state_nxt;
  logic              decode_ok_r, decode_ok_nxt;
  logic              loaded_r, loaded_nxt;
  logic [TW_W-1:0]   tw_r;
  logic [TH_W-1:0]   th_r;

  logic              out_valid_r, out_valid_nxt;
  logic              out_ok_r, out_ok_nxt;
  logic [COL_W-1:0]  out_rd_r, out_rd_nxt;

  logic [POS_W-1:0]  x_r, y_r, w_r, h_r;
  logic [COL_W-1:0]  red_r, green_r, blue_r, alpha_r;
  logic              ri_ok_r;
  logic [COL_W-1:0]  res_rd_r, res_rd_nxt;

  logic              black_r, black_nxt;
  logic [TW_W-1:0]   x_end_r, x_end_nxt;
  logic [TH_W-1:0]   y_end_r, y_end_nxt;
  logic [BC_W-1:0]   bx0_r, bx0_nxt, bx1_r, bx1_nxt, bc_r, bc_nxt;
  logic [2:0]        lo_r, lo_nxt, hi_r, hi_nxt;
  logic [TH_W-1:0]   dy_r, dy_nxt;
  logic [RB_W-1:0]   row_base_r, row_base_nxt;
  logic              iss_r, iss_nxt;
  logic              pend_r, pend_nxt;
  logic [SA_W-1:0]   pend_addr_r, pend_addr_nxt;
  logic [7:0]        pend_mask_r, pend_mask_nxt;

  logic [CNT_W-1:0]  clr_cnt_r, clr_cnt_nxt, clr_lim_r, clr_lim_nxt;

  logic              in_acc;
  logic              cfg_wr;
  logic              init_fail;

  logic [STR_W-1:0]  stride;
  logic [12:0]       xe_sum, ye_sum;
  logic [TW_W-1:0]   x_end_c;
  logic [TH_W-1:0]   y_end_c;
  logic [LUMA_W-1:0] luma_sum;
  logic [TW_W-1:0]   x_last;
  logic [TW_W-1:0]   w_bytes;
  logic [PROD_W-1:0] prod;
  logic [2:0]        lo_c, hi_c;
  logic [7:0]        mask_c;
  logic [RB_W-1:0]   draw_addr;
  logic              draw_in;

  logic              ram_we;
  logic [SA_W-1:0]   ram_waddr, ram_raddr;
  logic [7:0]        ram_wdata, ram_rdata;

  r2mb_ram #(
    .WIDTH (8),
    .DEPTH (STORE_BYTES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    case (cfg_paddr[2])
      REG_TW:  cfg_prdata = CFG_DW'(tw_r);
      REG_TH:  cfg_prdata = CFG_DW'(th_r);
      default: cfg_prdata = '0;
    endcase
  end

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = '{status_ok: out_ok_r, read_byte: out_rd_r};

  // init size check
  assign init_fail = (in_ch.data.width == '0) || (in_ch.data.height == '0) ||
                     ((tw_r != '0) && (in_ch.data.width != POS_W'(tw_r))) ||
                     ((th_r != '0) && (in_ch.data.height != POS_W'(th_r)));

  // draw set-up arithmetic
  assign stride   = STR_W'((11'(tw_r) + 11'd7) >> 3);
  assign xe_sum   = 13'(x_r) + 13'(w_r);
  assign ye_sum   = 13'(y_r) + 13'(h_r);
  assign x_end_c  = (xe_sum > 13'(tw_r)) ? tw_r : xe_sum[TW_W-1:0];
  assign y_end_c  = (ye_sum > 13'(th_r)) ? th_r : ye_sum[TH_W-1:0];
  assign luma_sum = LUMA_W'(red_r) * LUMA_W'(LUMA_R) +
                    LUMA_W'(green_r) * LUMA_W'(LUMA_G) +
                    LUMA_W'(blue_r) * LUMA_W'(LUMA_B);
  assign x_last   = x_end_r - TW_W'(1);
  assign w_bytes  = TW_W'((13'(w_r) + 13'd7) >> 3);
  assign prod     = PROD_W'(w_bytes) * PROD_W'(h_r);

  // per byte bit mask, msb is the leftmost pixel
  assign lo_c      = (bc_r == bx0_r) ? lo_r : 3'd0;
  assign hi_c      = (bc_r == bx1_r) ? hi_r : 3'd7;
  assign mask_c    = (8'hFF >> lo_c) & (8'hFF << (3'd7 - hi_c));
  assign draw_addr = row_base_r + RB_W'(bc_r);
  assign draw_in   = 32'(draw_addr) < STORE_BYTES;

  // ram ports
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pend_addr_r;
    ram_wdata = black_r ? (ram_rdata | pend_mask_r) : (ram_rdata & ~pend_mask_r);
    ram_raddr = SA_W'(in_ch.data.read_index);
    if (state_r == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = SA_W'(clr_cnt_r);
      ram_wdata = '0;
    end else if (state_r == ST_DRAW) begin
      ram_we = pend_r;
    end
    if (state_r == ST_DRAW) begin
      ram_raddr = SA_W'(draw_addr);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    decode_ok_nxt = decode_ok_r;
    loaded_nxt    = loaded_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_ok_nxt    = out_ok_r;
    out_rd_nxt    = out_rd_r;
    res_rd_nxt    = res_rd_r;
    black_nxt     = black_r;
    x_end_nxt     = x_end_r;
    y_end_nxt     = y_end_r;
    bx0_nxt       = bx0_r;
    bx1_nxt       = bx1_r;
    bc_nxt        = bc_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    dy_nxt        = dy_r;
    row_base_nxt  = row_base_r;
    iss_nxt       = iss_r;
    pend_nxt      = 1'b0;
    pend_addr_nxt = pend_addr_r;
    pend_mask_nxt = pend_mask_r;
    clr_cnt_nxt   = clr_cnt_r;
    clr_lim_nxt   = clr_lim_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          res_rd_nxt = '0;
          state_nxt  = ST_RESP;
          case (in_ch.data.mode)
            MODE_INIT: begin
              if (init_fail) begin
                decode_ok_nxt = 1'b0;
              end else begin
                state_nxt = ST_ICNT;
              end
            end
            MODE_DRAW: begin
              if (decode_ok_r) begin
                if (!loaded_r || tw_r == '0 || th_r == '0) begin
                  decode_ok_nxt = 1'b0;
                end else begin
                  state_nxt = ST_DCLIP;
                end
              end
            end
            MODE_READ: state_nxt = ST_READ;
            default:   state_nxt = ST_RESP;
          endcase
        end
      end
      ST_ICNT: begin
        clr_cnt_nxt = '0;
        clr_lim_nxt = (32'(prod) > STORE_BYTES) ? CNT_W'(STORE_BYTES) : CNT_W'(prod);
        state_nxt   = ST_CLEAR;
      end
      ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + CNT_W'(1);
        if (clr_cnt_r + CNT_W'(1) == clr_lim_r) begin
          loaded_nxt = 1'b1;
          state_nxt  = ST_RESP;
        end
      end
      ST_DCLIP: begin
        black_nxt = (alpha_r != '0) && (32'(luma_sum) < 32'(LUMA_LIMIT));
        x_end_nxt = x_end_c;
        y_end_nxt = y_end_c;
        if ((x_r >= POS_W'(x_end_c)) || (y_r >= POS_W'(y_end_c))) begin
          state_nxt = ST_RESP;
        end else begin
          state_nxt = ST_DBASE;
        end
      end
      ST_DBASE: begin
        bx0_nxt      = x_r[TW_W-1:3];
        bc_nxt       = x_r[TW_W-1:3];
        bx1_nxt      = x_last[TW_W-1:3];
        lo_nxt       = x_r[2:0];
        hi_nxt       = x_last[2:0];
        dy_nxt       = y_r[TH_W-1:0];
        row_base_nxt = RB_W'(y_r[TH_W-1:0]) * RB_W'(stride);
        iss_nxt      = 1'b1;
        state_nxt    = ST_DRAW;
      end
      ST_DRAW: begin
        // read of the next byte overlaps the write-back of the previous one
        if (iss_r) begin
          pend_nxt      = draw_in;
          pend_addr_nxt = SA_W'(draw_addr);
          pend_mask_nxt = mask_c;
          if (bc_r == bx1_r) begin
            bc_nxt       = bx0_r;
            row_base_nxt = row_base_r + RB_W'(stride);
            dy_nxt       = dy_r + TH_W'(1);
            if ((TH_W+1)'(dy_r) + (TH_W+1)'(1) == (TH_W+1)'(y_end_r)) begin
              iss_nxt = 1'b0;
            end
          end else begin
            bc_nxt = bc_r + BC_W'(1);
          end
        end else if (!pend_r) begin
          state_nxt = ST_RESP;
        end
      end
      ST_READ: begin
        res_rd_nxt = ri_ok_r ? ram_rdata : '0;
        state_nxt  = ST_RESP;
      end
      ST_RESP: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_ok_nxt    = decode_ok_r;
          out_rd_nxt    = res_rd_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      decode_ok_r <= 1'b1;
      loaded_r    <= 1'b0;
      tw_r        <= TW_RESET;
      th_r        <= TH_RESET;
      out_valid_r <= 1'b0;
      iss_r       <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      decode_ok_r <= decode_ok_nxt;
      loaded_r    <= loaded_nxt;
      out_valid_r <= out_valid_nxt;
      iss_r       <= iss_nxt;
      pend_r      <= pend_nxt;
      if (cfg_wr) begin
        case (cfg_paddr[2])
          REG_TW:  tw_r <= cfg_pwdata[TW_W-1:0];
          REG_TH:  th_r <= cfg_pwdata[TH_W-1:0];
          default: tw_r <= tw_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      x_r     <= in_ch.data.pos_x;
      y_r     <= in_ch.data.pos_y;
      w_r     <= in_ch.data.width;
      h_r     <= in_ch.data.height;
      red_r   <= in_ch.data.red;
      green_r <= in_ch.data.green;
      blue_r  <= in_ch.data.blue;
      alpha_r <= in_ch.data.alpha;
      ri_ok_r <= 32'(in_ch.data.read_index) < STORE_BYTES;
    end
    out_ok_r    <= out_ok_nxt;
    out_rd_r    <= out_rd_nxt;
    res_rd_r    <= res_rd_nxt;
    black_r     <= black_nxt;
    x_end_r     <= x_end_nxt;
    y_end_r     <= y_end_nxt;
    bx0_r       <= bx0_nxt;
    bx1_r       <= bx1_nxt;
    bc_r        <= bc_nxt;
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    dy_r        <= dy_nxt;
    row_base_r  <= row_base_nxt;
    pend_addr_r <= pend_addr_nxt;
    pend_mask_r <= pend_mask_nxt;
    clr_cnt_r   <= clr_cnt_nxt;
    clr_lim_r   <= clr_lim_nxt;
  end

  // ok status only ever returns through reset
  a_ok_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    !decode_ok_r |=> !decode_ok_r)
    else $error("decode status recovered without reset");

  a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !ram_we)
    else $error("bitmap write while idle");

  a_clear_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> (clr_cnt_r < clr_lim_r))
    else $error("clear sweep ran past its byte count");

  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_RESP))
    else $error("result raised outside the response step");

  a_pend_in_draw: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> (state_r == ST_DRAW) && $past(iss_r))
    else $error("pending write-back outside a draw");

endmodule
